### src/tmr_pkg.sv
package tmr_pkg;

    // Default geometry
    localparam int DEF_TEXT_COLS     = 80;
    localparam int DEF_TEXT_ROWS     = 30;
    localparam int DEF_GLYPH_HEIGHT  = 16;
    localparam int DEF_ICON_SIDE     = 128;
    localparam int DEF_COLOR_ENTRIES = 256;

    // Fixed shift for reciprocal-multiply division by a geometry constant
    localparam int RECIP_SHIFT = 16;

    // Widest store addresses over the supported geometry range
    localparam int CELL_ADDR_W  = 13;
    localparam int GLYPH_ADDR_W = 12;
    localparam int ICON_ADDR_W  = 13;
    localparam int COLOR_ADDR_W = 10;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ICON_LEFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ICON_TOP  = 2'd1;
    localparam logic [10:0] ICON_TOP_RESET = 11'd1024;

    // Pixel-pair select codes taken from the 2-bit pattern
    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_HIGH = 2'd1;
    localparam logic [1:0] SEL_LOW  = 2'd2;
    localparam logic [1:0] SEL_BOTH = 2'd3;

    typedef enum logic [2:0] {
        ACT_WR_CELL  = 3'd0,
        ACT_WR_GLYPH = 3'd1,
        ACT_WR_ICON  = 3'd2,
        ACT_WR_COLOR = 3'd3,
        ACT_RENDER   = 3'd4
    } t_act;

    typedef struct packed {
        logic [2:0]  action;
        logic [11:0] address;
        logic [15:0] value;
        logic [8:0]  line;
        logic [7:0]  frame;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_pair;
        logic        from_icon;
    } t_out_item;

    // Classified transaction handed from front to back
    typedef struct packed {
        t_act                    act;
        logic [15:0]             wdata;
        logic [CELL_ADDR_W-1:0]  cell_addr;
        logic [GLYPH_ADDR_W-1:0] glyph_addr;  // write address, or glyph line on render
        logic [ICON_ADDR_W-1:0]  icon_addr;
        logic [COLOR_ADDR_W-1:0] color_addr;
        logic                    slot_on;
        logic                    text_on;
        logic                    icon_on;
        logic                    icon_ok;
        logic [1:0]              quarter;
    } t_job;

endpackage

### src/tmr_front.sv
module tmr_front #(
    parameter int TEXT_COLS     = tmr_pkg::DEF_TEXT_COLS,
    parameter int TEXT_ROWS     = tmr_pkg::DEF_TEXT_ROWS,
    parameter int GLYPH_HEIGHT  = tmr_pkg::DEF_GLYPH_HEIGHT,
    parameter int ICON_SIDE     = tmr_pkg::DEF_ICON_SIDE,
    parameter int COLOR_ENTRIES = tmr_pkg::DEF_COLOR_ENTRIES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  tmr_pkg::t_in_item                  i_in_item,
    input  logic                               i_cfg_valid,
    input  logic [tmr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tmr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_busy,
    input  logic                               i_q_full,
    output logic                               o_push,
    output tmr_pkg::t_job                      o_job
);
    import tmr_pkg::*;

    localparam int CELL_COUNT     = TEXT_COLS * TEXT_ROWS;
    localparam int GLYPH_COUNT    = 256 * GLYPH_HEIGHT;
    localparam int ICON_ROW_BYTES = ICON_SIDE / 8;
    localparam int ICON_BYTES     = ICON_SIDE * ICON_ROW_BYTES;
    localparam int LINE_SLOTS     = TEXT_COLS * 4;
    localparam int LINE_RECIP     = (1 << RECIP_SHIFT) / GLYPH_HEIGHT;
    localparam int COLOR_RECIP    = (1 << RECIP_SHIFT) / COLOR_ENTRIES;

    // Configuration registers
    logic [9:0]  r_icon_left;
    logic [10:0] r_icon_top;

    // Stage 1: classify, estimate quotients, icon window tests
    logic        r_s1_valid;
    t_act        r_s1_act;
    logic [11:0] r_s1_addr;
    logic [15:0] r_s1_value;
    logic [8:0]  r_s1_line;
    logic [7:0]  r_s1_csum;
    logic [5:0]  r_s1_lq0;
    logic [3:0]  r_s1_cq0;
    logic        r_s1_slot_on;
    logic        r_s1_icon_on;
    logic [7:0]  r_s1_dy;
    logic [6:0]  r_s1_d;

    // Stage 2: corrected quotients, color index, icon byte index
    logic                    r_s2_valid;
    t_act                    r_s2_act;
    logic [11:0]             r_s2_addr;
    logic [15:0]             r_s2_value;
    logic [5:0]              r_s2_q;
    logic [3:0]              r_s2_rem;
    logic [COLOR_ADDR_W-1:0] r_s2_cidx;
    logic                    r_s2_slot_on;
    logic                    r_s2_icon_on;
    logic [ICON_ADDR_W-1:0]  r_s2_icon_idx;
    logic                    r_s2_icon_ok;
    logic [1:0]              r_s2_quarter;

    // Stage 3: finished transaction waiting for the queue
    logic r_s3_valid;
    t_job r_s3_job;

    logic        adv;
    logic        accept;
    logic        keep;
    t_act        in_act;
    logic [22:0] lprod;
    logic [20:0] cprod;
    logic [7:0]  csum;
    logic [11:0] l12;
    logic [11:0] top12;
    logic [11:0] dy12;
    logic [11:0] d12;
    logic        rows_hit;
    logic        cols_hit;
    logic [9:0]  lrem0;
    logic [10:0] crem0;
    logic [13:0] icon_bi;
    logic [13:0] cell_sum;
    logic        text_on;
    t_job        job;

    assign adv        = !r_s3_valid || !i_q_full;
    assign o_in_stall = i_busy || !adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_s3_valid && !i_q_full;
    assign o_job      = r_s3_job;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icon_left <= '0;
            r_icon_top  <= ICON_TOP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ICON_LEFT: r_icon_left <= i_cfg_data[9:0];
                CFG_ICON_TOP:  r_icon_top  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Stage 1 logic
    always_comb begin
        in_act = t_act'(i_in_item.action);
        case (in_act)
            ACT_WR_CELL:  keep = 14'(i_in_item.address) < 14'(CELL_COUNT);
            ACT_WR_GLYPH: keep = 13'(i_in_item.address) < 13'(GLYPH_COUNT);
            ACT_WR_ICON:  keep = 14'(i_in_item.address) < 14'(ICON_BYTES);
            ACT_WR_COLOR: keep = i_in_item.address < 12'(COLOR_ENTRIES);
            ACT_RENDER:   keep = 1'b1;
            default:      keep = 1'b0;
        endcase

        lprod = 23'(i_in_item.line) * 23'(LINE_RECIP);
        csum  = i_in_item.frame + i_in_item.line[7:0];
        cprod = 21'(csum) * 21'(COLOR_RECIP);

        l12      = 12'(i_in_item.line);
        top12    = 12'(r_icon_top);
        dy12     = l12 - top12;
        rows_hit = (l12 > top12) && (l12 < top12 + 12'(ICON_SIDE));
        d12      = i_in_item.address - 12'(r_icon_left[9:1]);
        cols_hit = (i_in_item.address >= 12'(r_icon_left[9:1])) &&
                   (d12 < 12'(ICON_SIDE / 2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_act     <= in_act;
            r_s1_addr    <= i_in_item.address;
            r_s1_value   <= i_in_item.value;
            r_s1_line    <= i_in_item.line;
            r_s1_csum    <= csum;
            r_s1_lq0     <= lprod[21:16];
            r_s1_cq0     <= cprod[19:16];
            r_s1_slot_on <= i_in_item.address < 12'(LINE_SLOTS);
            r_s1_icon_on <= rows_hit && cols_hit;
            r_s1_dy      <= dy12[7:0];
            r_s1_d       <= d12[6:0];
        end
    end

    // Stage 2 logic: one compare-and-subtract fixes each estimate
    always_comb begin
        lrem0   = 10'(r_s1_line) - 10'(r_s1_lq0) * 10'(GLYPH_HEIGHT);
        crem0   = 11'(r_s1_csum) - 11'(r_s1_cq0) * 11'(COLOR_ENTRIES);
        icon_bi = 14'(r_s1_dy) * 14'(ICON_ROW_BYTES) + 14'(r_s1_d[6:2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_act     <= r_s1_act;
            r_s2_addr    <= r_s1_addr;
            r_s2_value   <= r_s1_value;
            r_s2_slot_on <= r_s1_slot_on;
            r_s2_icon_on <= r_s1_icon_on;
            r_s2_quarter <= r_s1_icon_on ? r_s1_d[1:0] : r_s1_addr[1:0];
            if (lrem0 >= 10'(GLYPH_HEIGHT)) begin
                r_s2_q   <= r_s1_lq0 + 6'd1;
                r_s2_rem <= 4'(lrem0 - 10'(GLYPH_HEIGHT));
            end else begin
                r_s2_q   <= r_s1_lq0;
                r_s2_rem <= lrem0[3:0];
            end
            if (crem0 >= 11'(COLOR_ENTRIES)) begin
                r_s2_cidx <= COLOR_ADDR_W'(crem0 - 11'(COLOR_ENTRIES));
            end else begin
                r_s2_cidx <= crem0[COLOR_ADDR_W-1:0];
            end
            r_s2_icon_ok  <= icon_bi < 14'(ICON_BYTES);
            r_s2_icon_idx <= (icon_bi < 14'(ICON_BYTES)) ? icon_bi[ICON_ADDR_W-1:0] : '0;
        end
    end

    // Stage 3 logic: cell address and transaction assembly
    always_comb begin
        text_on  = 7'(r_s2_q) < 7'(TEXT_ROWS);
        cell_sum = 14'(r_s2_q) * 14'(TEXT_COLS) + 14'(r_s2_addr[11:2]);

        job            = '0;
        job.act        = r_s2_act;
        job.wdata      = r_s2_value;
        job.slot_on    = r_s2_slot_on;
        job.text_on    = text_on;
        job.icon_on    = r_s2_icon_on;
        job.icon_ok    = r_s2_icon_ok;
        job.quarter    = r_s2_quarter;
        if (r_s2_act == ACT_RENDER) begin
            job.cell_addr  = (text_on && r_s2_slot_on) ? cell_sum[CELL_ADDR_W-1:0] : '0;
            job.glyph_addr = GLYPH_ADDR_W'(r_s2_rem);
            job.icon_addr  = r_s2_icon_idx;
            job.color_addr = r_s2_cidx;
        end else begin
            job.cell_addr  = CELL_ADDR_W'(r_s2_addr);
            job.glyph_addr = r_s2_addr;
            job.icon_addr  = ICON_ADDR_W'(r_s2_addr);
            job.color_addr = r_s2_addr[COLOR_ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_job <= job;
        end
    end

endmodule

### src/tmr_queue.sv
module tmr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tmr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output tmr_pkg::t_job o_head
);
    import tmr_pkg::*;

    t_job                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_slot[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

endmodule

### src/tmr_back.sv
module tmr_back #(
    parameter int TEXT_COLS     = tmr_pkg::DEF_TEXT_COLS,
    parameter int TEXT_ROWS     = tmr_pkg::DEF_TEXT_ROWS,
    parameter int GLYPH_HEIGHT  = tmr_pkg::DEF_GLYPH_HEIGHT,
    parameter int ICON_SIDE     = tmr_pkg::DEF_ICON_SIDE,
    parameter int COLOR_ENTRIES = tmr_pkg::DEF_COLOR_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  tmr_pkg::t_job      i_q_head,
    output logic               o_pop,
    output logic               o_busy,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tmr_pkg::t_out_item o_out_item
);
    import tmr_pkg::*;

    localparam int CELL_COUNT  = TEXT_COLS * TEXT_ROWS;
    localparam int GLYPH_COUNT = 256 * GLYPH_HEIGHT;
    localparam int ICON_BYTES  = ICON_SIDE * (ICON_SIDE / 8);
    localparam int CAW  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int GAW  = $clog2(GLYPH_COUNT);
    localparam int IAW  = $clog2(ICON_BYTES);
    localparam int KAW  = $clog2(COLOR_ENTRIES);
    localparam int CLR_LEN = (CELL_COUNT > ICON_BYTES) ? CELL_COUNT : ICON_BYTES;
    localparam int CLW  = $clog2(CLR_LEN + 1);

    // Stores
    logic [7:0]  r_cell_mem  [CELL_COUNT];
    logic [7:0]  r_glyph_mem [GLYPH_COUNT];
    logic [7:0]  r_icon_mem  [ICON_BYTES];
    logic [15:0] r_color_mem [COLOR_ENTRIES];

    // Clearing pass after reset
    logic           r_busy;
    logic [CLW-1:0] r_clr_idx;

    // Stage A: cell, color and icon reads
    logic        r_a_valid;
    t_job        r_a_job;
    logic [7:0]  r_cell_q;
    logic [15:0] r_color_q;
    logic [7:0]  r_icon_q;

    // Stage B: glyph read
    logic        r_b_valid;
    t_job        r_b_job;
    logic [15:0] r_b_color;
    logic [7:0]  r_b_icon;
    logic [7:0]  r_glyph_q;

    // Output register
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      adv;
    logic [11:0] gsum;
    t_out_item result;

    function automatic logic [31:0] pick_word(input logic [7:0] bits,
                                              input logic [1:0] quarter,
                                              input logic [15:0] color);
        logic [1:0]  sel;
        logic [31:0] word;
        case (quarter)
            2'd0:    sel = bits[7:6];
            2'd1:    sel = bits[5:4];
            2'd2:    sel = bits[3:2];
            default: sel = bits[1:0];
        endcase
        case (sel)
            SEL_HIGH: word = {color, 16'h0000};
            SEL_LOW:  word = {16'h0000, color};
            SEL_BOTH: word = {color, color};
            default:  word = 32'h0000_0000;
        endcase
        return word;
    endfunction

    assign adv         = !r_out_valid || !i_out_stall;
    assign o_pop       = adv && !i_q_empty && !r_busy;
    assign o_busy      = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Clearing sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == CLW'(CLR_LEN - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Character cell store
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_clr_idx < CLW'(CELL_COUNT)) begin
                r_cell_mem[r_clr_idx[CAW-1:0]] <= 8'h00;
            end
        end else if (o_pop && i_q_head.act == ACT_WR_CELL) begin
            r_cell_mem[i_q_head.cell_addr[CAW-1:0]] <= i_q_head.wdata[7:0];
        end
        if (adv) begin
            r_cell_q <= r_cell_mem[i_q_head.cell_addr[CAW-1:0]];
        end
    end

    // Icon bitmap store
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_clr_idx < CLW'(ICON_BYTES)) begin
                r_icon_mem[r_clr_idx[IAW-1:0]] <= 8'h00;
            end
        end else if (o_pop && i_q_head.act == ACT_WR_ICON) begin
            r_icon_mem[i_q_head.icon_addr[IAW-1:0]] <= i_q_head.wdata[7:0];
        end
        if (adv) begin
            r_icon_q <= r_icon_mem[i_q_head.icon_addr[IAW-1:0]];
        end
    end

    // Line color table
    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_head.act == ACT_WR_COLOR) begin
            r_color_mem[i_q_head.color_addr[KAW-1:0]] <= i_q_head.wdata;
        end
        if (adv) begin
            r_color_q <= r_color_mem[i_q_head.color_addr[KAW-1:0]];
        end
    end

    // Stage A control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_job <= i_q_head;
        end
    end

    // Glyph index from the fetched character code
    assign gsum = 12'(r_cell_q) * 12'(GLYPH_HEIGHT) + 12'(r_a_job.glyph_addr[3:0]);

    // Glyph store, written and read as the transaction leaves stage A
    always_ff @(posedge i_clk) begin
        if (adv && r_a_valid && r_a_job.act == ACT_WR_GLYPH) begin
            r_glyph_mem[r_a_job.glyph_addr[GAW-1:0]] <= r_a_job.wdata[7:0];
        end
        if (adv) begin
            r_glyph_q <= r_glyph_mem[gsum[GAW-1:0]];
        end
    end

    // Stage B control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_job   <= r_a_job;
            r_b_color <= r_color_q;
            r_b_icon  <= r_icon_q;
        end
    end

    // Pixel pair selection: icon overrides text inside its window
    always_comb begin
        result = '0;
        if (r_b_job.slot_on) begin
            if (r_b_job.icon_on) begin
                result.pixel_pair = pick_word(r_b_job.icon_ok ? r_b_icon : 8'h00,
                                              r_b_job.quarter, r_b_color);
                result.from_icon  = 1'b1;
            end else begin
                result.pixel_pair = pick_word(r_b_job.text_on ? r_glyph_q : 8'h00,
                                              r_b_job.quarter, r_b_color);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_b_valid && r_b_job.act == ACT_RENDER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_item <= result;
        end
    end

endmodule

### src/text_mode_scanline_renderer.sv
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+-------------------------------
// in        | in        | i_in_valid / o_in_stall | i_in_item  (tmr_pkg::t_in_item)
// out       | out       | o_out_valid / i_out_stall | o_out_item (tmr_pkg::t_out_item)
// cfg       | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained while no stall or clearing pass holds it; a render
// result passes three front stages, the queue, two store-read stages and the output
// register; the two store-read stages follow from the chained cell-then-glyph store
// reads.
// After reset a clearing pass zeroes the cell and icon stores, one entry per
// cycle, over max(TEXT_COLS*TEXT_ROWS, ICON_SIDE*ICON_SIDE/8) entries (2400 at the
// defaults); o_in_stall stays high meanwhile. Configuration is always taken.
// Output stalls freeze the back end only; the front keeps taking transactions
// until the four-entry queue fills.
module text_mode_scanline_renderer #(
    parameter int TEXT_COLS     = tmr_pkg::DEF_TEXT_COLS,
    parameter int TEXT_ROWS     = tmr_pkg::DEF_TEXT_ROWS,
    parameter int GLYPH_HEIGHT  = tmr_pkg::DEF_GLYPH_HEIGHT,
    parameter int ICON_SIDE     = tmr_pkg::DEF_ICON_SIDE,
    parameter int COLOR_ENTRIES = tmr_pkg::DEF_COLOR_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tmr_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tmr_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tmr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tmr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tmr_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    logic busy;
    t_job front_job;
    t_job q_head;

    assign o_cfg_ready = 1'b1;

    // Front: accept, classify, compute store addresses
    tmr_front #(
        .TEXT_COLS    (TEXT_COLS),
        .TEXT_ROWS    (TEXT_ROWS),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .ICON_SIDE    (ICON_SIDE),
        .COLOR_ENTRIES(COLOR_ENTRIES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_busy     (busy),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (front_job)
    );

    // Decoupling queue
    tmr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (front_job),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_head (q_head)
    );

    // Back: stores, pixel selection, output register
    tmr_back #(
        .TEXT_COLS    (TEXT_COLS),
        .TEXT_ROWS    (TEXT_ROWS),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .ICON_SIDE    (ICON_SIDE),
        .COLOR_ENTRIES(COLOR_ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_head   (q_head),
        .o_pop      (q_pop),
        .o_busy     (busy),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import tmr_pkg::*;

    // Geometry at the default parameters
    localparam int CELL_COUNT     = DEF_TEXT_COLS * DEF_TEXT_ROWS;
    localparam int GLYPH_COUNT    = 256 * DEF_GLYPH_HEIGHT;
    localparam int ICON_ROW_BYTES = DEF_ICON_SIDE / 8;
    localparam int ICON_BYTES     = DEF_ICON_SIDE * ICON_ROW_BYTES;
    localparam int LINE_SLOTS     = DEF_TEXT_COLS * 4;
    localparam int COLOR_WRAP     = 256;

    // Character codes the cells may hold: 0..7 and 248..255
    localparam int GLYPH_CHARS = 16;

    // Unused register index, written once to show it is ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;

    // Action codes outside the defined set
    localparam logic [2:0] ACT_BAD_FIRST = 3'd5;
    localparam logic [2:0] ACT_BAD_LAST  = 3'd7;

    localparam int SETTLE_CYCLES    = 16;
    localparam int RANDOM_PHASES    = 8;
    localparam int RANDOM_PER_PHASE = 52;

    // Mirror of the renderer stores; predicts one pixel-pair word per render
    class scanline_checker;
        logic [7:0]  cells  [CELL_COUNT];
        logic [7:0]  glyphs [GLYPH_COUNT];
        logic [7:0]  icons  [ICON_BYTES];
        logic [15:0] colors [DEF_COLOR_ENTRIES];
        int          icon_left;
        int          icon_top;
        t_out_item   expected_words [$];
        int          faults;

        function new();
            foreach (cells[k]) cells[k] = '0;
            foreach (glyphs[k]) glyphs[k] = '0;
            foreach (icons[k]) icons[k] = '0;
            foreach (colors[k]) colors[k] = '0;
            icon_left = 0;
            icon_top  = int'(ICON_TOP_RESET);
            faults    = 0;
        endfunction

        // 2-bit pattern at the quarter picks none, high, low or both halves
        function logic [31:0] pair_word(logic [7:0] bits, logic [1:0] quarter,
                                        logic [15:0] color);
            logic [1:0] sel;
            sel = 2'(bits >> (6 - 2 * quarter));
            case (sel)
                SEL_HIGH: pair_word = {color, 16'h0000};
                SEL_LOW:  pair_word = {16'h0000, color};
                SEL_BOTH: pair_word = {color, color};
                default:  pair_word = '0;
            endcase
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ICON_LEFT: icon_left = int'(data[9:0]);
                CFG_ICON_TOP:  icon_top  = int'(data[10:0]);
                default: ;
            endcase
        endfunction

        // Accepted input transaction: update stores or queue the expected word
        function void note_item(t_in_item it);
            int          slot;
            int          ln;
            int          row;
            int          start;
            int          d;
            int          bi;
            logic [15:0] color;
            logic [7:0]  glyph;
            logic [7:0]  ib;
            t_out_item   want;
            slot = int'(it.address);
            ln   = int'(it.line);
            case (it.action)
                ACT_WR_CELL:  if (slot < CELL_COUNT) cells[slot] = it.value[7:0];
                ACT_WR_GLYPH: if (slot < GLYPH_COUNT) glyphs[slot] = it.value[7:0];
                ACT_WR_ICON:  if (slot < ICON_BYTES) icons[slot] = it.value[7:0];
                ACT_WR_COLOR: if (slot < DEF_COLOR_ENTRIES) colors[slot] = it.value;
                ACT_RENDER: begin
                    want = '0;
                    if (slot < LINE_SLOTS) begin
                        color = colors[((int'(it.frame) + ln) % COLOR_WRAP)
                                       % DEF_COLOR_ENTRIES];
                        row   = ln / DEF_GLYPH_HEIGHT;
                        glyph = '0;
                        if (row < DEF_TEXT_ROWS)
                            glyph = glyphs[int'(cells[row * DEF_TEXT_COLS + slot / 4])
                                           * DEF_GLYPH_HEIGHT + ln % DEF_GLYPH_HEIGHT];
                        want.pixel_pair = pair_word(glyph, 2'(slot), color);
                        // icon covers lines strictly below its top row
                        start = icon_left >> 1;
                        if (ln > icon_top && ln < icon_top + DEF_ICON_SIDE &&
                            slot >= start && slot - start < DEF_ICON_SIDE / 2) begin
                            d  = slot - start;
                            bi = (ln - icon_top) * ICON_ROW_BYTES + d / 4;
                            ib = (bi < ICON_BYTES) ? icons[bi] : 8'h00;
                            want.pixel_pair = pair_word(ib, 2'(d), color);
                            want.from_icon  = 1'b1;
                        end
                    end
                    expected_words.push_back(want);
                end
                default: ;
            endcase
        endfunction

        // Accepted output transaction against the oldest expectation
        function void check_word(t_out_item got);
            t_out_item want;
            if (expected_words.size() == 0) begin
                $error("unexpected result: pixel_pair %h from_icon %b",
                       got.pixel_pair, got.from_icon);
                faults++;
            end else begin
                want = expected_words.pop_front();
                if (got.pixel_pair !== want.pixel_pair) begin
                    $error("pixel_pair: expected %h, got %h",
                           want.pixel_pair, got.pixel_pair);
                    faults++;
                end
                if (got.from_icon !== want.from_icon) begin
                    $error("from_icon: expected %b, got %b", want.from_icon, got.from_icon);
                    faults++;
                end
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_item   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_item;
    logic                  cfg_ready;

    int gap_pct   = 0;
    int stall_pct = 0;
    int cur_left  = 0;
    int cur_top   = int'(ICON_TOP_RESET);

    scanline_checker sb;

    text_mode_scanline_renderer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Observe both channels at the clock edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) sb.note_item(in_item);
            if (out_valid && !out_stall) sb.check_word(out_item);
        end
    end

    // Map 0..15 onto the character codes whose glyphs get loaded
    function automatic logic [7:0] char_code(input logic [3:0] k);
        return {{5{k[3]}}, k[2:0]};
    endfunction

    // Present one transaction, with random idle cycles ahead of it
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_fields(input logic [2:0] act, input int addr, input logic [15:0] val,
                               input int ln, input int fr);
        t_in_item it;
        it.action  = act;
        it.address = 12'(addr);
        it.value   = val;
        it.line    = 9'(ln);
        it.frame   = 8'(fr);
        send_item(it);
    endtask

    // Hold the sender until every expected word is back, then let the pipe settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_icon(input int left, input int top, input bit poke_spare);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx[0] = CFG_ICON_LEFT;
        val[0] = CFG_DATA_W'(left);
        idx[1] = CFG_SPARE;
        val[1] = CFG_DATA_W'($urandom);
        idx[2] = CFG_ICON_TOP;
        val[2] = CFG_DATA_W'(top);
        cfg_valid <= 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (k != 1 || poke_spare) begin
                cfg_index <= idx[k];
                cfg_data  <= val[k];
                @(posedge clk);
                while (!cfg_ready) @(posedge clk);
                sb.write_reg(idx[k], val[k]);
            end
        end
        cfg_valid <= 1'b0;
        cur_left = left;
        cur_top  = top;
    endtask

    initial begin
        t_in_item it;
        int       pick;
        int       left;
        int       top;
        int       ln;

        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Load the color table and every glyph row a cell may point at,
        // so no render reads an unwritten entry
        for (int c = 0; c < GLYPH_CHARS; c++)
            for (int r = 0; r < DEF_GLYPH_HEIGHT; r++)
                send_fields(ACT_WR_GLYPH, int'(char_code(4'(c))) * DEF_GLYPH_HEIGHT + r,
                            16'($urandom), $urandom_range(0, 511), $urandom);
        for (int a = 0; a < DEF_COLOR_ENTRIES; a++)
            send_fields(ACT_WR_COLOR, a, 16'($urandom), $urandom_range(0, 511), $urandom);

        // Directed: store edges, ignored writes, unknown actions, icon hidden
        send_fields(ACT_WR_CELL, 0, 16'hFFFF, 0, 0);
        send_fields(ACT_WR_CELL, CELL_COUNT - 1, 16'h41F9, 511, 255);
        send_fields(ACT_WR_CELL, CELL_COUNT, 16'h00AA, 0, 0);
        send_fields(ACT_WR_ICON, 0, 16'hA5E4, 0, 0);
        send_fields(ACT_WR_ICON, ICON_BYTES - 1, 16'h001B, 0, 0);
        send_fields(ACT_WR_ICON, ICON_BYTES, 16'h00FF, 0, 0);
        send_fields(ACT_WR_ICON, 16, 16'h00E4, 0, 0);
        send_fields(ACT_WR_COLOR, DEF_COLOR_ENTRIES - 1, 16'hFFFF, 0, 0);
        send_fields(ACT_WR_COLOR, 0, 16'h8001, 0, 0);
        send_fields(ACT_WR_COLOR, DEF_COLOR_ENTRIES, 16'h1234, 0, 0);
        send_fields(ACT_WR_GLYPH, GLYPH_COUNT - 1, 16'hFFE4, 0, 0);
        send_fields(ACT_WR_GLYPH, 0, 16'h001B, 0, 0);
        for (int a = ACT_BAD_FIRST; a <= ACT_BAD_LAST; a++)
            send_fields(3'(a), 0, 16'hFFFF, 0, 0);
        send_fields(ACT_RENDER, 0, 16'h0000, 0, 0);
        send_fields(ACT_RENDER, 1, 16'h0000, 0, 0);
        send_fields(ACT_RENDER, 2, 16'h0000, 0, 0);
        send_fields(ACT_RENDER, 3, 16'h0000, 15, 255);
        send_fields(ACT_RENDER, LINE_SLOTS - 1, 16'h0000, 479, 255);
        send_fields(ACT_RENDER, LINE_SLOTS, 16'h0000, 0, 0);
        send_fields(ACT_RENDER, 4095, 16'hFFFF, 479, 0);
        // below the text area
        send_fields(ACT_RENDER, 0, 16'h0000, 480, 0);
        send_fields(ACT_RENDER, 5, 16'h0000, 511, 255);

        // Directed: icon at the origin, its top row and edges
        wait_idle();
        program_icon(0, 0, 1'b1);
        send_fields(ACT_RENDER, 0, 16'h0000, 0, 0);
        send_fields(ACT_RENDER, 0, 16'h0000, 1, 0);
        send_fields(ACT_RENDER, DEF_ICON_SIDE / 2 - 1, 16'h0000, DEF_ICON_SIDE - 1, 7);
        send_fields(ACT_RENDER, 0, 16'h0000, DEF_ICON_SIDE, 0);
        send_fields(ACT_RENDER, DEF_ICON_SIDE / 2, 16'h0000, 1, 0);

        // Random phases: each with its own icon setting and idle pattern
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin left = 0;   top = int'(ICON_TOP_RESET); end
                1: begin left = 639; top = 0; end
                2: begin left = 0;   top = 0; end
                3: begin left = 638; top = 352; end
                4: begin left = $urandom_range(0, 639); top = $urandom_range(300, 479); end
                5: begin left = 1;   top = 1023; end
                6: begin left = $urandom_range(0, 639); top = $urandom_range(0, 1024); end
                default: begin left = 320; top = 200; end
            endcase
            program_icon(left, top, 1'b0);
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 84; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 84; end
                default: begin gap_pct = 36; stall_pct = 36; end
            endcase

            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                it.value   = 16'($urandom);
                it.line    = 9'($urandom_range(0, 479));
                it.frame   = 8'($urandom);
                it.address = 12'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    it.action = ACT_RENDER;
                    it.address = 12'($urandom_range(0, LINE_SLOTS - 1));
                    case ($urandom_range(0, 9))
                        0: it.address = 12'($urandom_range(LINE_SLOTS, 4095));
                        1, 2, 3, 4: begin
                            // aim at the icon area and just around it
                            ln = cur_top + $urandom_range(0, DEF_ICON_SIDE);
                            if (ln <= 511) it.line = 9'(ln);
                            it.address = 12'((cur_left >> 1)
                                             + $urandom_range(0, DEF_ICON_SIDE / 2 + 1) - 1);
                        end
                        5: it.line = 9'($urandom_range(480, 511));
                        default: ;
                    endcase
                end else if (pick < 70) begin
                    it.action  = ACT_WR_CELL;
                    it.address = 12'($urandom_range(0, CELL_COUNT - 1));
                end else if (pick < 82) begin
                    it.action  = ACT_WR_ICON;
                    it.address = 12'($urandom_range(0, ICON_BYTES - 1));
                end else if (pick < 88) begin
                    it.action = ACT_WR_GLYPH;
                end else if (pick < 94) begin
                    it.action  = ACT_WR_COLOR;
                    it.address = 12'($urandom_range(0, DEF_COLOR_ENTRIES - 1));
                end else begin
                    // noise: any action code, any address
                    it.action = 3'($urandom_range(0, 7));
                end
                // cells only ever hold codes with loaded glyphs
                if (it.action == ACT_WR_CELL) it.value[7:0] = char_code(4'($urandom));
                send_item(it);
            end
        end

        wait_idle();
        if (sb.faults == 0 && sb.expected_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
